@@ hdl/gbu_pkg.sv @@
`timescale 1ns / 1ps

package gbu_pkg;

   // framebuffer line width in pixels
   localparam int          LINE_WIDTH = 160;
   localparam logic [15:0] LINE_W16   = 16'(LINE_WIDTH);

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PIXEL_DEPTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GLYPH_WIDTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GLYPH_HEIGHT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_X     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Y     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_INK_COLOR    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_PAPER_COLOR  = 3'd6;

   // register reset values
   localparam logic [3:0]  RST_PIXEL_DEPTH = 4'd1;
   localparam logic [11:0] RST_ORIGIN      = 12'd4;
   localparam logic [15:0] RST_INK         = 16'h0000;
   localparam logic [15:0] RST_PAPER       = 16'h4f4f;

   // decoded pixel depth
   localparam logic [1:0] DC_1BPP = 2'd0;
   localparam logic [1:0] DC_2BPP = 2'd1;
   localparam logic [1:0] DC_4BPP = 2'd2;
   localparam logic [1:0] DC_8BPP = 2'd3;

   typedef struct packed {
      logic [3:0]  pixel_depth;
      logic [7:0]  glyph_width;
      logic [7:0]  glyph_height;
      logic [11:0] origin_x;
      logic [11:0] origin_y;
      logic [15:0] ink_color;
      logic [15:0] paper_color;
   } cfg_type;

   // one classified input byte, as queued between front and back
   typedef struct packed {
      logic [7:0] bitmap_byte;
      logic       glyph_start;
      logic       depth_error;
      logic [1:0] depth_code;
   } item_type;

endpackage

@@ hdl/glyph_bitmap_unpacker.sv @@
`timescale 1ns / 1ps
// Channel  | Dir | Beat
// req_*    | in  | tdata[7:0] bitmap_byte, tuser[0] glyph_start
// rsp_*    | out | tdata pixel_address/color/level, tlast last_of_byte,
//          |     | tuser[0] last_of_glyph, tuser[1] depth_error
// csr_*    | in  | write enable, 3-bit register index, 16-bit data
//
// The back end emits one pixel a cycle unless the output stalls; that pixel
// loop sets the rate. A byte yields 8, 4, 2 or 1 pixels at 1, 2, 4 or 8 bpp,
// fewer when the glyph ends inside it; an error byte yields one error beat.
// Reset (synchronous) loads register defaults, empties the two-beat queue
// and clears the row/column position. An output stall holds the result
// register; the queue keeps taking bytes until its two slots are full.

module glyph_bitmap_unpacker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] bitmap_byte
   input  logic [0:0]                     req_tuser,   // [0] glyph_start
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [39:0]                    rsp_tdata,   // [15:0] pixel_address,
                                                       // [31:16] pixel_color,
                                                       // [39:32] pixel_level
   output logic                           rsp_tlast,   // last_of_byte
   output logic [1:0]                     rsp_tuser,   // [0] last_of_glyph,
                                                       // [1] depth_error
   input  logic                           csr_we,
   input  logic [gbu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gbu_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import gbu_pkg::*;

   cfg_type  cfg;
   logic     q_valid;
   logic     q_pop;
   item_type q_item;

   gbu_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gbu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .pixel_depth (cfg.pixel_depth),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .q_valid     (q_valid),
      .q_pop       (q_pop),
      .q_item      (q_item)
   );

   gbu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_item     (q_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ hdl/gbu_regs.sv @@
`timescale 1ns / 1ps

module gbu_regs (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [gbu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gbu_pkg::CSR_DATA_W-1:0] csr_wdata,
   output gbu_pkg::cfg_type               cfg
);
   import gbu_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_PIXEL_DEPTH:  cfg_in.pixel_depth  = csr_wdata[3:0];
            REG_GLYPH_WIDTH:  cfg_in.glyph_width  = csr_wdata[7:0];
            REG_GLYPH_HEIGHT: cfg_in.glyph_height = csr_wdata[7:0];
            REG_ORIGIN_X:     cfg_in.origin_x     = csr_wdata[11:0];
            REG_ORIGIN_Y:     cfg_in.origin_y     = csr_wdata[11:0];
            REG_INK_COLOR:    cfg_in.ink_color    = csr_wdata[15:0];
            REG_PAPER_COLOR:  cfg_in.paper_color  = csr_wdata[15:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixel_depth  <= RST_PIXEL_DEPTH;
         cfg_ff.glyph_width  <= 8'd0;
         cfg_ff.glyph_height <= 8'd0;
         cfg_ff.origin_x     <= RST_ORIGIN;
         cfg_ff.origin_y     <= RST_ORIGIN;
         cfg_ff.ink_color    <= RST_INK;
         cfg_ff.paper_color  <= RST_PAPER;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hdl/gbu_front.sv @@
`timescale 1ns / 1ps

module gbu_front (
   input  logic              clock,
   input  logic              reset,
   input  logic [3:0]        pixel_depth,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] bitmap_byte
   input  logic [0:0]        req_tuser,   // [0] glyph_start
   output logic              q_valid,
   input  logic              q_pop,
   output gbu_pkg::item_type q_item
);
   import gbu_pkg::*;

   item_type   ent_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   item_type   cls;

   // depth 3 runs as 4; anything outside 1,2,3,4,8 is an error byte
   always_comb begin
      cls.bitmap_byte = req_tdata;
      cls.glyph_start = req_tuser[0];
      cls.depth_error = 1'b0;
      case (pixel_depth)
         4'd1:    cls.depth_code = DC_1BPP;
         4'd2:    cls.depth_code = DC_2BPP;
         4'd3:    cls.depth_code = DC_4BPP;
         4'd4:    cls.depth_code = DC_4BPP;
         4'd8:    cls.depth_code = DC_8BPP;
         default: begin
            cls.depth_code  = DC_8BPP;
            cls.depth_error = 1'b1;
         end
      endcase
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (cnt_ff != 2'd0);
   assign q_item     = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= cls;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

@@ hdl/gbu_back.sv @@
`timescale 1ns / 1ps

module gbu_back (
   input  logic              clock,
   input  logic              reset,
   input  gbu_pkg::cfg_type  cfg,
   input  logic              q_valid,
   output logic              q_pop,
   input  gbu_pkg::item_type q_item,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [39:0]       rsp_tdata,   // [15:0] pixel_address, [31:16] pixel_color,
                                          // [39:32] pixel_level
   output logic              rsp_tlast,   // last_of_byte
   output logic [1:0]        rsp_tuser    // [0] last_of_glyph, [1] depth_error
);
   import gbu_pkg::*;

   // current byte
   logic       cur_act_ff, cur_act_in;
   logic       cur_err_ff, cur_err_in;
   logic [1:0] cur_code_ff, cur_code_in;
   logic [7:0] cur_bits_ff, cur_bits_in;
   logic [2:0] cur_k_ff, cur_k_in;

   // glyph position
   logic [7:0] row_ff, row_in;
   logic [7:0] col_ff, col_in;
   logic       done_ff, done_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_addr_ff, rsp_addr_in;
   logic [15:0] rsp_color_ff, rsp_color_in;
   logic [7:0]  rsp_level_ff, rsp_level_in;
   logic        rsp_lob_ff, rsp_lob_in;
   logic        rsp_log_ff, rsp_log_in;
   logic        rsp_err_ff, rsp_err_in;

   logic        adv, step, box_ok, col_wrap, row_end, glyph_last;
   logic        pix_fire, byte_end, finish, load;
   logic [7:0]  level, bits_shift;
   logic [2:0]  last_k;
   logic [8:0]  col_inc, row_inc;
   logic [12:0] ysum;
   logic [15:0] addr;

   always_comb begin
      case (cur_code_ff)
         DC_1BPP: begin
            level      = {7'd0, cur_bits_ff[7]};
            bits_shift = {cur_bits_ff[6:0], 1'b0};
            last_k     = 3'd7;
         end
         DC_2BPP: begin
            level      = {6'd0, cur_bits_ff[7:6]};
            bits_shift = {cur_bits_ff[5:0], 2'b0};
            last_k     = 3'd3;
         end
         DC_4BPP: begin
            level      = {4'd0, cur_bits_ff[7:4]};
            bits_shift = {cur_bits_ff[3:0], 4'b0};
            last_k     = 3'd1;
         end
         default: begin
            level      = cur_bits_ff;
            bits_shift = 8'd0;
            last_k     = 3'd0;
         end
      endcase
   end

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign step       = cur_act_ff && adv;
   assign box_ok     = !done_ff && (row_ff < cfg.glyph_height) && (col_ff < cfg.glyph_width);
   assign col_inc    = {1'b0, col_ff} + 9'd1;
   assign row_inc    = {1'b0, row_ff} + 9'd1;
   assign col_wrap   = col_inc >= {1'b0, cfg.glyph_width};
   assign row_end    = col_wrap && (row_inc >= {1'b0, cfg.glyph_height});
   assign glyph_last = (row_inc == {1'b0, cfg.glyph_height}) &&
                       (col_inc == {1'b0, cfg.glyph_width});
   assign pix_fire   = step && !cur_err_ff && box_ok;
   // a byte ends on error, outside the box, at the glyph's last pixel, or after its last pixel
   assign byte_end   = cur_err_ff || !box_ok || row_end || (cur_k_ff == last_k);
   assign finish     = step && byte_end;
   assign load       = q_valid && (!cur_act_ff || finish);
   assign q_pop      = load;

   assign ysum = {1'b0, cfg.origin_y} + {5'd0, row_ff};
   assign addr = 16'({3'd0, ysum} * LINE_W16) + {4'd0, cfg.origin_x} + {8'd0, col_ff};

   always_comb begin
      cur_act_in  = cur_act_ff;
      cur_err_in  = cur_err_ff;
      cur_code_in = cur_code_ff;
      cur_bits_in = cur_bits_ff;
      cur_k_in    = cur_k_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      done_in     = done_ff;

      if (finish) begin
         cur_act_in = 1'b0;
      end
      if (pix_fire) begin
         cur_bits_in = bits_shift;
         cur_k_in    = cur_k_ff + 3'd1;
         if (col_wrap) begin
            col_in = 8'd0;
            row_in = row_inc[7:0];
         end else begin
            col_in = col_inc[7:0];
         end
         if (row_end) begin
            done_in = 1'b1;
         end
      end else if (step && !cur_err_ff) begin
         done_in = 1'b1;
      end

      if (load) begin
         cur_act_in  = 1'b1;
         cur_err_in  = q_item.depth_error;
         cur_code_in = q_item.depth_code;
         cur_bits_in = q_item.bitmap_byte;
         cur_k_in    = 3'd0;
         if (q_item.glyph_start) begin
            row_in  = 8'd0;
            col_in  = 8'd0;
            done_in = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_color_in = rsp_color_ff;
      rsp_level_in = rsp_level_ff;
      rsp_lob_in   = rsp_lob_ff;
      rsp_log_in   = rsp_log_ff;
      rsp_err_in   = rsp_err_ff;
      if (adv) begin
         rsp_valid_in = step && (cur_err_ff || box_ok);
         if (cur_err_ff) begin
            rsp_addr_in  = 16'd0;
            rsp_color_in = 16'd0;
            rsp_level_in = 8'd0;
            rsp_lob_in   = 1'b1;
            rsp_log_in   = 1'b0;
            rsp_err_in   = 1'b1;
         end else begin
            rsp_addr_in  = addr;
            rsp_color_in = (level != 8'd0) ? cfg.ink_color : cfg.paper_color;
            rsp_level_in = level;
            rsp_lob_in   = byte_end;
            rsp_log_in   = glyph_last;
            rsp_err_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_err_ff   <= cur_err_in;
      cur_code_ff  <= cur_code_in;
      cur_bits_ff  <= cur_bits_in;
      cur_k_ff     <= cur_k_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_color_ff <= rsp_color_in;
      rsp_level_ff <= rsp_level_in;
      rsp_lob_ff   <= rsp_lob_in;
      rsp_log_ff   <= rsp_log_in;
      rsp_err_ff   <= rsp_err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_act_ff   <= 1'b0;
         row_ff       <= 8'd0;
         col_ff       <= 8'd0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_act_ff   <= cur_act_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_level_ff, rsp_color_ff, rsp_addr_ff};
   assign rsp_tlast  = rsp_lob_ff;
   assign rsp_tuser  = {rsp_err_ff, rsp_log_ff};

   a_err_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast && (rsp_tdata == 40'd0) && !rsp_tuser[0])
      else $error("error beat carries pixel data");

   a_glyph_ends_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)
      else $error("last pixel of glyph not last of byte");

   a_done_after_glyph: assert property (@(posedge clock) disable iff (reset)
      pix_fire && glyph_last && !(load && q_item.glyph_start) |=> done_ff)
      else $error("glyph not closed after bottom-right pixel");

   a_pop_needs_room: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid && (!cur_act_ff || finish))
      else $error("queue popped while byte in progress");

endmodule
